@@ rtl/core/lpi_pkg.sv @@
// Shared constants for the line/plane intersection unit: configuration register map.
package lpi_pkg;

    // Configuration write channel widths.
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IW-1:0] CFG_NORMAL_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_NORMAL_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_NORMAL_Z = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_POINT_X  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_POINT_Y  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_POINT_Z  = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_THRESH   = 3'd6;

    // Reset value of the parallel threshold (about 1e-7 at 32 fraction bits).
    localparam logic [CFG_DW-1:0] THRESH_RST = 32'd429;

endpackage

@@ rtl/core/lpi_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit and passes the item on.
module lpi_div_cell #(
    parameter int RW  = 116,
    parameter int SW  = 70,
    parameter int QW  = 32,
    parameter int PLW = 198,
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [RW-1:0]  i_rem,
    input  logic [SW-1:0]  i_den,
    input  logic [QW-1:0]  i_q,
    input  logic [PLW-1:0] i_pay,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [RW-1:0]  o_rem,
    output logic [SW-1:0]  o_den,
    output logic [QW-1:0]  o_q,
    output logic [PLW-1:0] o_pay
);

    logic           r_v;
    logic [RW-1:0]  r_rem, n_rem;
    logic [SW-1:0]  r_den;
    logic [QW-1:0]  r_q, n_q;
    logic [PLW-1:0] r_pay;
    logic [RW-1:0]  trial;

    assign o_ready = !r_v || i_ready;

    // Compare the partial remainder with the shifted divisor and subtract on a fit.
    always_comb begin
        trial = RW'(i_den) << BIT;
        n_rem = i_rem;
        n_q   = i_q;
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_q[BIT] = 1'b1;
        end
    end

    // Valid bit of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Data of the cell.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_q   <= n_q;
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_q     = r_q;
    assign o_pay   = r_pay;

endmodule

@@ rtl/core/line_plane_intersection_unit.sv @@
// Top level of the line/plane intersection unit: setup, divider chain and hit point.
//
// Usage:
//   Each beat on the slave stream carries one segment: start_x, start_y, start_z,
//   end_x, end_y, end_z as signed fixed-point coordinates, start_x in the lowest bits.
//   Each beat on the master stream carries the hit point (hit_x, hit_y, hit_z in
//   tdata) and two flags in tuser: is_parallel (bit 0) and saturated (bit 1).
//   One result beat leaves for every segment beat, in order.
//   The plane normal, a point on the plane and the parallel threshold are written
//   on the configuration channel, which is always ready; write only while idle.
// Timing:
//   Five setup stages, one divider cell per quotient bit, then three stages for
//   scaling and clamping. Throughput is one segment per cycle while the receiver
//   keeps tready high; the divider chain of cells sets the depth.
// Reset and stall:
//   Synchronous reset empties the pipeline and loads the default plane (normal +z, through the origin).
//   When the receiver stalls, the result holds on the master side and the stages
//   behind it keep filling until the chain is full; only then does tready drop.
module line_plane_intersection_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // Configuration write channel.
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [lpi_pkg::CFG_IW-1:0]                   i_cfg_index,
    input  logic [lpi_pkg::CFG_DW-1:0]                   i_cfg_data,
    // Segment stream.
    input  logic                                         i_s_tvalid,
    output logic                                         o_s_tready,
    // tdata: start_x, start_y, start_z, end_x, end_y, end_z (lowest first)
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]           i_s_tdata,
    // Hit stream.
    output logic                                         o_m_tvalid,
    input  logic                                         i_m_tready,
    // tdata: hit_x, hit_y, hit_z (lowest first)
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]           o_m_tdata,
    // tuser: is_parallel, saturated (lowest first)
    output logic [1:0]                                   o_m_tuser
);

    import lpi_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int UW  = CW + 1;
    localparam int PW  = UW + CW;
    localparam int SW  = PW + 2;
    localparam int RW  = SW + ((CW > FB) ? CW : FB);
    localparam int PLW = 3*CW + 3*UW + 3;
    localparam int MW  = UW + CW;
    localparam int HW  = MW - FB;
    localparam int XW  = ((HW > CW) ? HW : CW) + 2;
    localparam int ODW = ((3*CW+7)/8)*8;
    localparam int PO_SNEG = 3*CW + 3*UW;

    localparam logic [CW-1:0] NZ_RST = CW'(64'd1 << FB);
    localparam logic [CW-1:0] S_POS  = CW'((64'd1 << (CW-1)) - 64'd1);
    localparam logic [CW-1:0] S_NEG  = CW'(64'd1 << (CW-1));
    localparam logic signed [XW-1:0] CMAX = XW'((64'sd1 <<< (CW-1)) - 64'sd1);
    localparam logic signed [XW-1:0] CMIN = -CMAX - XW'(1);

    // Configuration registers.
    logic signed [CW-1:0] r_nrm [3];
    logic signed [CW-1:0] r_pnt [3];
    logic [CFG_DW-1:0]    r_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= NZ_RST;
            r_pnt[0] <= '0;
            r_pnt[1] <= '0;
            r_pnt[2] <= '0;
            r_thr    <= THRESH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NORMAL_X: r_nrm[0] <= i_cfg_data[CW-1:0];
                CFG_NORMAL_Y: r_nrm[1] <= i_cfg_data[CW-1:0];
                CFG_NORMAL_Z: r_nrm[2] <= i_cfg_data[CW-1:0];
                CFG_POINT_X:  r_pnt[0] <= i_cfg_data[CW-1:0];
                CFG_POINT_Y:  r_pnt[1] <= i_cfg_data[CW-1:0];
                CFG_POINT_Z:  r_pnt[2] <= i_cfg_data[CW-1:0];
                CFG_THRESH:   r_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables; a stage moves when it is empty or its successor moves.
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_vs, r_vm, r_vo;
    logic en0, en1, en2, en3, en4, en_s, en_m, en_o;
    logic c_valid [CW+1];
    logic c_ready [CW+1];

    assign en_o = !r_vo || i_m_tready;
    assign en_m = !r_vm || en_o;
    assign en_s = !r_vs || en_m;
    assign c_ready[CW] = en_s;
    assign en4 = !r_v4 || c_ready[0];
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;
    assign o_s_tready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vs <= 1'b0;
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en0)  r_v0 <= i_s_tvalid;
            if (en1)  r_v1 <= r_v0;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en4)  r_v4 <= r_v3;
            if (en_s) r_vs <= c_valid[CW];
            if (en_m) r_vm <= r_vs;
            if (en_o) r_vo <= r_vm;
        end
    end

    // Stage 0: direction u = end - start and offset start - point.
    logic signed [CW-1:0] st_in [3];
    logic signed [CW-1:0] en_in [3];
    logic signed [CW-1:0] r_st0 [3];
    logic signed [UW-1:0] r_u0  [3];
    logic signed [UW-1:0] r_d0  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            st_in[i] = i_s_tdata[i*CW +: CW];
            en_in[i] = i_s_tdata[(i+3)*CW +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            for (int i = 0; i < 3; i++) begin
                r_st0[i] <= st_in[i];
                r_u0[i]  <= UW'(en_in[i]) - UW'(st_in[i]);
                r_d0[i]  <= UW'(st_in[i]) - UW'(r_pnt[i]);
            end
        end
    end

    // Stage 1: products with the normal, one multiplier per term.
    logic signed [CW-1:0] r_st1 [3];
    logic signed [UW-1:0] r_u1  [3];
    logic signed [PW-1:0] r_pu1 [3];
    logic signed [PW-1:0] r_pd1 [3];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int i = 0; i < 3; i++) begin
                r_st1[i] <= r_st0[i];
                r_u1[i]  <= r_u0[i];
                r_pu1[i] <= PW'(r_u0[i]) * PW'(r_nrm[i]);
                r_pd1[i] <= PW'(r_d0[i]) * PW'(r_nrm[i]);
            end
        end
    end

    // Stage 2: dot products dp = u.n and (start - point).n.
    logic signed [CW-1:0] r_st2 [3];
    logic signed [UW-1:0] r_u2  [3];
    logic signed [SW-1:0] r_dp2, r_ns2;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int i = 0; i < 3; i++) begin
                r_st2[i] <= r_st1[i];
                r_u2[i]  <= r_u1[i];
            end
            r_dp2 <= SW'(r_pu1[0]) + SW'(r_pu1[1]) + SW'(r_pu1[2]);
            r_ns2 <= SW'(r_pd1[0]) + SW'(r_pd1[1]) + SW'(r_pd1[2]);
        end
    end

    // Stage 3: magnitudes, quotient sign and the parallel test.
    // The numerator is the negated offset product, so it is negative when that sum is positive.
    logic signed [CW-1:0] r_st3 [3];
    logic signed [UW-1:0] r_u3  [3];
    logic [SW-1:0]        r_dmag3, r_nmag3;
    logic                 r_sneg3, r_par3;
    logic [SW-1:0]        dmag, nmag;
    logic                 num_neg;

    always_comb begin
        dmag    = r_dp2[SW-1] ? SW'(-r_dp2) : SW'(r_dp2);
        nmag    = r_ns2[SW-1] ? SW'(-r_ns2) : SW'(r_ns2);
        num_neg = !r_ns2[SW-1] && (r_ns2 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int i = 0; i < 3; i++) begin
                r_st3[i] <= r_st2[i];
                r_u3[i]  <= r_u2[i];
            end
            r_dmag3 <= dmag;
            r_nmag3 <= nmag;
            r_sneg3 <= num_neg != r_dp2[SW-1];
            r_par3  <= (dmag == '0) || (dmag < SW'(r_thr));
        end
    end

    // Stage 4: scaled numerator and the quotient overflow check.
    logic [RW-1:0]  r_rem4;
    logic [SW-1:0]  r_den4;
    logic [PLW-1:0] r_pay4;
    logic [RW-1:0]  rem0;

    assign rem0 = RW'(r_nmag3) << FB;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_rem4 <= rem0;
            r_den4 <= r_dmag3;
            r_pay4 <= {rem0 >= (RW'(r_dmag3) << CW), r_par3, r_sneg3,
                       r_u3[2], r_u3[1], r_u3[0], r_st3[2], r_st3[1], r_st3[0]};
        end
    end

    // Divider chain: one cell per quotient bit, most significant first.
    logic [RW-1:0]  c_rem [CW+1];
    logic [SW-1:0]  c_den [CW+1];
    logic [CW-1:0]  c_q   [CW+1];
    logic [PLW-1:0] c_pay [CW+1];

    assign c_valid[0] = r_v4;
    assign c_rem[0]   = r_rem4;
    assign c_den[0]   = r_den4;
    assign c_q[0]     = '0;
    assign c_pay[0]   = r_pay4;

    for (genvar k = 0; k < CW; k++) begin : g_cell
        lpi_div_cell #(
            .RW (RW),
            .SW (SW),
            .QW (CW),
            .PLW(PLW),
            .BIT(CW - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(c_valid[k]),
            .o_ready(c_ready[k]),
            .i_rem  (c_rem[k]),
            .i_den  (c_den[k]),
            .i_q    (c_q[k]),
            .i_pay  (c_pay[k]),
            .o_valid(c_valid[k+1]),
            .i_ready(c_ready[k+1]),
            .o_rem  (c_rem[k+1]),
            .o_den  (c_den[k+1]),
            .o_q    (c_q[k+1]),
            .o_pay  (c_pay[k+1])
        );
    end

    // Stage S: clamp the line parameter to the coordinate range.
    logic [PLW-1:0]       pay_q;
    logic                 q_sneg, q_par, q_ovf;
    logic [CW-1:0]        lim;
    logic                 sat_s;
    logic signed [CW-1:0] r_sts [3];
    logic signed [UW-1:0] r_us  [3];
    logic [CW-1:0]        r_smag;
    logic                 r_sats, r_snegs, r_pars;

    always_comb begin
        pay_q  = c_pay[CW];
        q_sneg = pay_q[PO_SNEG];
        q_par  = pay_q[PO_SNEG+1];
        q_ovf  = pay_q[PO_SNEG+2];
        lim    = q_sneg ? S_NEG : S_POS;
        sat_s  = q_ovf || (c_q[CW] > lim);
    end

    always_ff @(posedge i_clk) begin
        if (en_s) begin
            for (int i = 0; i < 3; i++) begin
                r_sts[i] <= pay_q[i*CW +: CW];
                r_us[i]  <= pay_q[3*CW + i*UW +: UW];
            end
            r_smag  <= sat_s ? lim : c_q[CW];
            r_sats  <= sat_s;
            r_snegs <= q_sneg;
            r_pars  <= q_par;
        end
    end

    // Stage M: |u| * |s| for each axis.
    logic signed [CW-1:0] r_stm [3];
    logic [MW-1:0]        r_prod [3];
    logic                 r_pneg [3];
    logic                 r_satm, r_parm;
    logic [UW-1:0]        umag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            umag[i] = r_us[i][UW-1] ? UW'(-r_us[i]) : UW'(r_us[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_m) begin
            for (int i = 0; i < 3; i++) begin
                r_stm[i]  <= r_sts[i];
                r_prod[i] <= MW'(umag[i]) * MW'(r_smag);
                r_pneg[i] <= r_us[i][UW-1] != r_snegs;
            end
            r_satm <= r_sats;
            r_parm <= r_pars;
        end
    end

    // Output stage: scale down, add to start, clamp; a parallel line reports zero.
    logic signed [XW-1:0] stepv [3];
    logic signed [XW-1:0] sumv  [3];
    logic [CW-1:0]        hitv  [3];
    logic                 sat_o;
    logic [CW-1:0]        r_hit [3];
    logic                 r_par_o, r_sat_o;

    always_comb begin
        sat_o = r_satm;
        for (int i = 0; i < 3; i++) begin
            stepv[i] = r_pneg[i] ? -XW'(r_prod[i][MW-1:FB]) : XW'(r_prod[i][MW-1:FB]);
            sumv[i]  = XW'(r_stm[i]) + stepv[i];
            if (sumv[i] > CMAX) begin
                hitv[i] = CMAX[CW-1:0];
                sat_o   = 1'b1;
            end else if (sumv[i] < CMIN) begin
                hitv[i] = CMIN[CW-1:0];
                sat_o   = 1'b1;
            end else begin
                hitv[i] = sumv[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            for (int i = 0; i < 3; i++) begin
                r_hit[i] <= r_parm ? '0 : hitv[i];
            end
            r_par_o <= r_parm;
            r_sat_o <= !r_parm && sat_o;
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = ODW'({r_hit[2], r_hit[1], r_hit[0]});
    assign o_m_tuser  = {r_sat_o, r_par_o};

endmodule

@@ rtl/core/lpi_checker.sv @@
// Port-level checks for the line/plane intersection unit, bound to the top level.
module lpi_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_cfg_valid,
    input logic                                  o_cfg_ready,
    input logic [lpi_pkg::CFG_IW-1:0]            i_cfg_index,
    input logic [lpi_pkg::CFG_DW-1:0]            i_cfg_data,
    input logic                                  i_s_tvalid,
    input logic                                  o_s_tready,
    input logic [((6*COORD_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    input logic                                  o_m_tvalid,
    input logic                                  i_m_tready,
    input logic [((3*COORD_WIDTH+7)/8)*8-1:0]    o_m_tdata,
    input logic [1:0]                            o_m_tuser
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // A parallel result carries a zero point and no saturation.
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> (o_m_tdata == '0) && !o_m_tuser[1])
        else $error("parallel result with nonzero payload");

    // The input side only backs up when a result is held by a stalled receiver.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output stall");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result beat changed");

endmodule

bind line_plane_intersection_unit lpi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lpi_checker (.*);
